@@ design/gbn_pkg.sv @@
// Shared types and constants for the Go-Back-N sender window control.
// Used by gbn_ctrl, gbn_dp and the top level go_back_n_sender.
package gbn_pkg;

	// Sequence number and window widths
	localparam int SEQ_W      = 16;
	localparam int WIN_W      = 6;
	localparam int MAX_WINDOW = 32;
	localparam logic [WIN_W-1:0] MAX_WIN = WIN_W'(MAX_WINDOW);

	// Input request kinds (tuser on the slave side)
	typedef enum logic [1:0] {
		ACT_START = 2'd0,
		ACT_ACK   = 2'd1,
		ACT_TICK  = 2'd2
	} action_t;

	// Result kinds (tuser on the master side)
	typedef enum logic [1:0] {
		KIND_NEW    = 2'd0,
		KIND_RESENT = 2'd1,
		KIND_EXIT   = 2'd2
	} kind_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_FRAME_COUNT = 2'd0,
		CFG_WINDOW_SIZE = 2'd1,
		CFG_TIMEOUT     = 2'd2
	} cfg_idx_t;

	// What the datapath loads into the output register
	typedef enum logic [1:0] {
		EMIT_SEND      = 2'd0,
		EMIT_EXIT      = 2'd1,
		EMIT_BURST_NEW = 2'd2,
		EMIT_BURST_RES = 2'd3
	} emit_sel_t;

	// Controller states, one-hot
	typedef enum logic [4:0] {
		ST_IDLE      = 5'b00001,
		ST_EVAL      = 5'b00010,
		ST_SEND_WAIT = 5'b00100,
		ST_BURST_NEW = 5'b01000,
		ST_BURST_RES = 5'b10000
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic      load_in;
		logic      sess_start;
		logic      ack_apply;
		logic      timer_inc;
		logic      timer_timeout;
		logic      emit;
		emit_sel_t emit_sel;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		action_t action;
		logic    active;
		logic    ack_is_last;
		logic    can_send;
		logic    timeout;
		logic    burst_more;
		logic    burst_last;
		logic    out_room;
	} status_t;

endpackage

@@ design/go_back_n_sender.sv @@
// Top level of the Go-Back-N sender: controller plus datapath.
// Depends on gbn_pkg, gbn_ctrl and gbn_dp.
//
// Requests are taken one at a time; s_tready is high only while the
// controller is idle. An ack, or a tick that does not time out, is
// captured and evaluated and yields at most one result. A start or a
// timeout is captured and evaluated, then the burst counter walks the window
// and loads one frame per cycle into the output register whenever it has room;
// the burst length is up to the window size, at most 32. A timeout whose
// window holds no frame yields no result. A single output register holds
// each result until m_tready takes it. Configuration writes apply at once
// and should be made while no request is in progress.
module go_back_n_sender (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,    // [15:0] ack_number
	input  logic [1:0]  s_tuser,    // [1:0] action
	// result channel
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,    // [15:0] frame_number
	output logic [1:0]  m_tuser,    // [1:0] frame_kind
	output logic        m_tlast,
	// configuration write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);

	gbn_pkg::cmd_t    cmd;
	gbn_pkg::status_t status;

	gbn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	gbn_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_action  (s_tuser),
		.in_ack     (s_tdata),
		.cmd        (cmd),
		.status     (status),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_number (m_tdata),
		.out_kind   (m_tuser),
		.out_last   (m_tlast)
	);

	// One request at a time: ready drops right after an accept
	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request accepted while another is in progress");

	// A result is never loaded over one that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> status.out_room)
		else $error("output register overwritten");

	// Exit marker closes the session
	a_exit_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.emit_sel == gbn_pkg::EMIT_EXIT) |=> !status.active)
		else $error("session still active after exit marker");

	// Bursts only start from an evaluated request, with no request pending
	a_burst_after_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.sess_start || cmd.timer_timeout) |-> !s_tready)
		else $error("burst started while input side is open");

endmodule

@@ design/gbn_ctrl.sv @@
// Controller state machine of the Go-Back-N sender.
// Depends on gbn_pkg; drives gbn_dp through cmd_t and reads status_t.
module gbn_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  gbn_pkg::status_t status,
	output gbn_pkg::cmd_t    cmd
);

	gbn_pkg::state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gbn_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == gbn_pkg::ST_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			gbn_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = gbn_pkg::ST_EVAL;
				end
			end
			gbn_pkg::ST_EVAL: begin
				case (status.action)
					gbn_pkg::ACT_START: begin
						cmd.sess_start = 1'b1;
						state_d        = gbn_pkg::ST_BURST_NEW;
					end
					gbn_pkg::ACT_ACK: begin
						if (!status.active) begin
							state_d = gbn_pkg::ST_IDLE;
						end else if (status.ack_is_last) begin
							// exit marker; wait here until the output frees up
							if (status.out_room) begin
								cmd.emit     = 1'b1;
								cmd.emit_sel = gbn_pkg::EMIT_EXIT;
								state_d      = gbn_pkg::ST_IDLE;
							end
						end else begin
							cmd.ack_apply = 1'b1;
							if (!status.can_send) begin
								state_d = gbn_pkg::ST_IDLE;
							end else if (status.out_room) begin
								cmd.emit     = 1'b1;
								cmd.emit_sel = gbn_pkg::EMIT_SEND;
								state_d      = gbn_pkg::ST_IDLE;
							end else begin
								state_d = gbn_pkg::ST_SEND_WAIT;
							end
						end
					end
					gbn_pkg::ACT_TICK: begin
						if (!status.active) begin
							state_d = gbn_pkg::ST_IDLE;
						end else if (status.timeout) begin
							cmd.timer_timeout = 1'b1;
							state_d           = gbn_pkg::ST_BURST_RES;
						end else begin
							cmd.timer_inc = 1'b1;
							state_d       = gbn_pkg::ST_IDLE;
						end
					end
					default: begin
						state_d = gbn_pkg::ST_IDLE;
					end
				endcase
			end
			gbn_pkg::ST_SEND_WAIT: begin
				// window already advanced, the send was decided in EVAL
				if (status.out_room) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = gbn_pkg::EMIT_SEND;
					state_d      = gbn_pkg::ST_IDLE;
				end
			end
			gbn_pkg::ST_BURST_NEW, gbn_pkg::ST_BURST_RES: begin
				// one frame per cycle while the burst counter has frames left and the output has room
				if (!status.burst_more) begin
					state_d = gbn_pkg::ST_IDLE;
				end else if (status.out_room) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = (state_q == gbn_pkg::ST_BURST_NEW) ?
					               gbn_pkg::EMIT_BURST_NEW : gbn_pkg::EMIT_BURST_RES;
					if (status.burst_last) begin
						state_d = gbn_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = gbn_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

@@ design/gbn_dp.sv @@
// Datapath of the Go-Back-N sender: config registers, window state,
// timeout counter, burst counter and output register. Depends on gbn_pkg.
module gbn_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [gbn_pkg::SEQ_W-1:0]   cfg_wdata,
	input  logic [1:0]                  in_action,
	input  logic [gbn_pkg::SEQ_W-1:0]   in_ack,
	input  gbn_pkg::cmd_t               cmd,
	output gbn_pkg::status_t            status,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [gbn_pkg::SEQ_W-1:0]   out_number,
	output logic [1:0]                  out_kind,
	output logic                        out_last
);

	localparam int SW = gbn_pkg::SEQ_W;
	localparam int WW = gbn_pkg::WIN_W;

	// Configuration
	logic [SW-1:0] fc_q, tmo_q;
	logic [WW-1:0] ws_q;

	// Request payload
	gbn_pkg::action_t act_q;
	logic [SW-1:0]    ack_q;

	// Window state
	logic [SW-1:0] base_q, top_q, next_q, timer_q;
	logic          active_q;
	logic [WW-1:0] ofs_q;

	// Output register
	logic          ov_q;
	logic [SW-1:0] onum_q;
	gbn_pkg::kind_t okind_q;
	logic          olast_q;

	// Effective settings
	logic [SW-1:0] nf, tmo_eff;
	logic [WW-1:0] ws_eff;
	assign nf      = (fc_q == '0) ? SW'(1) : fc_q;
	assign tmo_eff = (tmo_q == '0) ? SW'(1) : tmo_q;
	assign ws_eff  = (ws_q == '0) ? WW'(1) :
	                 (ws_q > gbn_pkg::MAX_WIN) ? gbn_pkg::MAX_WIN : ws_q;

	// New-send check, with the base advanced by a matching ack
	logic          ack_match;
	logic [SW-1:0] base_adv, span, ws_m1;
	assign ack_match = (act_q == gbn_pkg::ACT_ACK) && (ack_q == base_q);
	assign base_adv  = ack_match ? base_q + SW'(1) : base_q;
	assign span      = top_q - base_adv;
	assign ws_m1     = SW'(ws_eff) - SW'(1);

	// Timeout compare
	logic [SW-1:0] timer_inc;
	assign timer_inc = timer_q + SW'(1);

	// Burst counter: frame = base + offset, kept one bit wider to compare to nf
	logic [SW:0]   sum, sum_inc;
	logic [WW-1:0] ofs_inc;
	logic          more, more_next;
	assign sum       = {1'b0, base_q} + (SW+1)'(ofs_q);
	assign sum_inc   = sum + (SW+1)'(1);
	assign ofs_inc   = ofs_q + WW'(1);
	assign more      = (ofs_q < ws_eff) && (sum < {1'b0, nf});
	assign more_next = (ofs_inc < ws_eff) && (sum_inc < {1'b0, nf});

	logic room;
	assign room = !ov_q || out_ready;

	// Status to the controller
	always_comb begin
		status.action      = act_q;
		status.active      = active_q;
		status.ack_is_last = (ack_q == nf - SW'(1));
		status.can_send    = (span != ws_m1) && (next_q != nf);
		status.timeout     = (timer_inc >= tmo_eff);
		status.burst_more  = more;
		status.burst_last  = !more_next;
		status.out_room    = room;
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q  <= SW'(8);
			ws_q  <= WW'(4);
			tmo_q <= SW'(1000);
		end else if (cfg_we) begin
			case (cfg_index)
				gbn_pkg::CFG_FRAME_COUNT: fc_q  <= cfg_wdata;
				gbn_pkg::CFG_WINDOW_SIZE: ws_q  <= cfg_wdata[WW-1:0];
				gbn_pkg::CFG_TIMEOUT:     tmo_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Request capture
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			act_q <= gbn_pkg::action_t'(in_action);
			ack_q <= in_ack;
		end
	end

	// Window, timer and burst state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			top_q    <= '0;
			next_q   <= '0;
			timer_q  <= '0;
			active_q <= 1'b0;
			ofs_q    <= '0;
		end else begin
			if (cmd.sess_start) begin
				active_q <= 1'b1;
				base_q   <= '0;
				top_q    <= ws_m1;
				timer_q  <= '0;
				ofs_q    <= '0;
			end
			if (cmd.ack_apply) begin
				timer_q <= '0;
				base_q  <= base_adv;
			end
			if (cmd.timer_inc) begin
				timer_q <= timer_inc;
			end
			if (cmd.timer_timeout) begin
				timer_q <= '0;
				ofs_q   <= '0;
			end
			if (cmd.emit) begin
				case (cmd.emit_sel)
					gbn_pkg::EMIT_SEND: begin
						top_q  <= top_q + SW'(1);
						next_q <= next_q + SW'(1);
					end
					gbn_pkg::EMIT_EXIT: begin
						timer_q  <= '0;
						active_q <= 1'b0;
					end
					gbn_pkg::EMIT_BURST_NEW: begin
						ofs_q  <= ofs_inc;
						next_q <= sum_inc[SW-1:0];
					end
					default: begin
						ofs_q <= ofs_inc;
					end
				endcase
			end
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.emit) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			case (cmd.emit_sel)
				gbn_pkg::EMIT_SEND: begin
					onum_q  <= next_q;
					okind_q <= gbn_pkg::KIND_NEW;
					olast_q <= 1'b1;
				end
				gbn_pkg::EMIT_EXIT: begin
					onum_q  <= '0;
					okind_q <= gbn_pkg::KIND_EXIT;
					olast_q <= 1'b1;
				end
				gbn_pkg::EMIT_BURST_NEW: begin
					onum_q  <= sum[SW-1:0];
					okind_q <= gbn_pkg::KIND_NEW;
					olast_q <= !more_next;
				end
				default: begin
					onum_q  <= sum[SW-1:0];
					okind_q <= gbn_pkg::KIND_RESENT;
					olast_q <= !more_next;
				end
			endcase
		end
	end

	assign out_valid  = ov_q;
	assign out_number = onum_q;
	assign out_kind   = okind_q;
	assign out_last   = olast_q;

endmodule

@@ verif/tb_go_back_n_sender.sv @@
// Self-checking testbench for go_back_n_sender: a directed table of requests, then random
// sessions, all checked frame by frame against typed results or a window-control predictor in this file.
// Depends on gbn_pkg and the design sources only.
`timescale 1ns / 1ps

module tb_go_back_n_sender;
	import gbn_pkg::*;

	localparam int         CYCLE_LIMIT  = 400000;
	localparam int         DRAIN_CYCLES = 48;
	localparam int         RANDOM_ITEMS = 85;
	localparam logic [1:0] ACT_UNKNOWN  = 2'd3;
	localparam logic [1:0] CFG_UNUSED   = 2'd3;

	// One frame the block is expected to emit
	typedef struct packed {
		logic [15:0] num;
		kind_t       kind;
		logic        last;
	} frame_t;

	// One directed row: a register write or a request, optionally with typed results
	typedef struct packed {
		bit          is_cfg;
		logic [1:0]  reg_sel;
		logic [15:0] value;
		logic [1:0]  act;
		logic [15:0] ack;
		int          n_exp;   // -1: take the predictor's results
		logic [15:0] first;
		kind_t       kind;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = 16'd0;   // [15:0] ack_number
	logic [1:0]  s_tuser = 2'd0;    // [1:0] action
	logic        m_tvalid;
	logic        m_tready = 1'b1;
	logic [15:0] m_tdata;           // [15:0] frame_number
	logic [1:0]  m_tuser;           // [1:0] frame_kind
	logic        m_tlast;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = 2'd0;
	logic [15:0] cfg_wdata = 16'd0;

	// Predictor copy of the registers and the window state
	logic [15:0] cfg_frames = 16'd8;
	logic [5:0]  cfg_window = 6'd4;
	logic [15:0] cfg_ticks  = 16'd1000;
	logic [15:0] base_num   = 16'd0;
	logic [15:0] top_num    = 16'd0;
	logic [15:0] next_num   = 16'd0;
	logic [15:0] idle_ticks = 16'd0;
	logic        hold_new   = 1'b0;
	logic        sess_on    = 1'b0;

	frame_t burst_q[$];
	frame_t frames_due[$];
	row_t   plan[$];
	int     errors  = 0;
	int     counted = 0;
	bit     quiet   = 1'b0;
	int     stall_left = 0;

	go_back_n_sender uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	function automatic void add_frame(input logic [15:0] num, input kind_t kind);
		frame_t f;
		if (burst_q.size() >= MAX_WINDOW) return;
		f.num  = num;
		f.kind = kind;
		f.last = 1'b0;
		burst_q.push_back(f);
	endfunction

	// New send if the window has room, nothing blocks it and frames remain
	function automatic void try_new(input int nf, input int ws);
		logic [15:0] span;
		span = top_num - base_num;
		if (span != 16'(ws - 1) && !hold_new && int'(next_num) != nf) begin
			add_frame(next_num, KIND_NEW);
			top_num  = top_num + 16'd1;
			next_num = next_num + 16'd1;
		end
		hold_new = 1'b0;
	endfunction

	// Frames caused by one request; leaves them in burst_q
	function automatic void predict_frames(input logic [1:0] act, input logic [15:0] ack);
		int nf;
		int ws;
		int tmo;
		int c;
		nf  = (cfg_frames == 16'd0) ? 1 : int'(cfg_frames);
		ws  = (cfg_window == 6'd0) ? 1 : (cfg_window > MAX_WINDOW) ? MAX_WINDOW : int'(cfg_window);
		tmo = (cfg_ticks == 16'd0) ? 1 : int'(cfg_ticks);
		burst_q.delete();
		case (act)
			ACT_START: begin
				sess_on    = 1'b1;
				base_num   = 16'd0;
				top_num    = 16'(ws - 1);
				idle_ticks = 16'd0;
				hold_new   = 1'b0;
				for (c = 0; c < nf && c < ws; c++)
					add_frame(16'(c), KIND_NEW);
				next_num = 16'(c);
				try_new(nf, ws);
			end
			ACT_ACK: begin
				if (sess_on) begin
					idle_ticks = 16'd0;
					if (int'(ack) == nf - 1) begin
						add_frame(16'd0, KIND_EXIT);
						sess_on = 1'b0;
					end else begin
						if (ack == base_num)
							base_num = base_num + 16'd1;
						try_new(nf, ws);
					end
				end
			end
			ACT_TICK: begin
				if (sess_on) begin
					idle_ticks = idle_ticks + 16'd1;
					if (int'(idle_ticks) >= tmo) begin
						// timeout: resend the whole window
						idle_ticks = 16'd0;
						for (c = int'(base_num); c < nf && c - int'(base_num) < ws; c++)
							add_frame(16'(c), KIND_RESENT);
						hold_new = 1'b1;
						try_new(nf, ws);
					end
				end
			end
			default: ;
		endcase
		if (burst_q.size() > 0)
			burst_q[burst_q.size() - 1].last = 1'b1;
	endfunction

	// ---------------------------------------------------------------- table rows

	function automatic row_t req(input logic [1:0] act, input logic [15:0] ack,
			input int n_exp = -1, input logic [15:0] first = 16'd0,
			input kind_t kind = KIND_NEW);
		row_t r;
		r = '0;
		r.act   = act;
		r.ack   = ack;
		r.n_exp = n_exp;
		r.first = first;
		r.kind  = kind;
		return r;
	endfunction

	function automatic row_t wr(input logic [1:0] sel, input logic [15:0] value);
		row_t r;
		r = '0;
		r.is_cfg  = 1'b1;
		r.reg_sel = sel;
		r.value   = value;
		return r;
	endfunction

	// ---------------------------------------------------------------- drivers

	// Offer one request, wait for it to be taken, then queue what it should cause
	task automatic push_request(input logic [1:0] act, input logic [15:0] ack,
			input int n_typed = -1, input logic [15:0] first = 16'd0,
			input kind_t kind = KIND_NEW);
		int gap;
		frame_t f;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 9);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= ack;
		do @(posedge clk); while (!s_tready);
		if (act == ACT_START || (sess_on && act != ACT_UNKNOWN))
			counted++;
		predict_frames(act, ack);
		if (n_typed >= 0) begin
			burst_q.delete();
			for (int i = 0; i < n_typed; i++) begin
				f.num  = first + 16'(i);
				f.kind = kind;
				f.last = (i == n_typed - 1);
				burst_q.push_back(f);
			end
		end
		foreach (burst_q[i])
			frames_due.push_back(burst_q[i]);
	endtask

	// Stop offering and let the block fall idle
	task automatic drain();
		s_tvalid <= 1'b0;
		while (frames_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] sel, input logic [15:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= sel;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (sel)
			CFG_FRAME_COUNT: cfg_frames = value;
			CFG_WINDOW_SIZE: cfg_window = value[5:0];
			CFG_TIMEOUT:     cfg_ticks  = value;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Result side: random stall bursts, none in the quiet tail
	always @(posedge clk) begin
		if (quiet) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready   <= 1'b0;
		end else if ($urandom_range(0, 4) == 0) begin
			stall_left <= $urandom_range(0, 8);
			m_tready   <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// ---------------------------------------------------------------- checker

	always @(posedge clk) begin
		frame_t f;
		if (arst_n && m_tvalid && m_tready) begin
			if (frames_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected frame: expected none, got number %0d kind %0d last %0b",
					$time, m_tdata, m_tuser, m_tlast);
			end else begin
				f = frames_due.pop_front();
				if (m_tdata !== f.num) begin
					errors++;
					$display("%0t: frame_number expected %0d, got %0d", $time, f.num, m_tdata);
				end
				if (m_tuser !== f.kind) begin
					errors++;
					$display("%0t: frame_kind expected %0d, got %0d", $time, f.kind, m_tuser);
				end
				if (m_tlast !== f.last) begin
					errors++;
					$display("%0t: last expected %0b, got %0b", $time, f.last, m_tlast);
				end
			end
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAILURE");
		$finish;
	end

	// ---------------------------------------------------------------- stimulus

	initial begin
		int goal;
		int phase;
		int steps;
		int pick;
		logic [15:0] frames;
		logic [15:0] window;
		logic [15:0] ticks;

		// Directed: reset defaults (8 frames, window 4, long timeout)
		plan.push_back(req(ACT_ACK, 16'd0, 0));                 // idle session
		plan.push_back(req(ACT_TICK, 16'd0, 0));
		plan.push_back(req(ACT_UNKNOWN, 16'hFFFF, 0));
		plan.push_back(req(ACT_START, 16'd0, 4, 16'd0, KIND_NEW));
		plan.push_back(req(ACT_ACK, 16'd0, 1, 16'd4, KIND_NEW));
		plan.push_back(req(ACT_ACK, 16'd5));                    // foreign ack
		plan.push_back(req(ACT_ACK, 16'd1));
		plan.push_back(req(ACT_TICK, 16'd0));
		plan.push_back(req(ACT_START, 16'hFFFF, 4, 16'd0, KIND_NEW));   // restart while active
		plan.push_back(req(ACT_ACK, 16'd7, 1, 16'd0, KIND_EXIT));
		plan.push_back(req(ACT_TICK, 16'd0, 0));
		// zero registers act as one
		plan.push_back(wr(CFG_TIMEOUT, 16'd0));
		plan.push_back(wr(CFG_WINDOW_SIZE, 16'd0));
		plan.push_back(wr(CFG_FRAME_COUNT, 16'd0));
		plan.push_back(wr(CFG_UNUSED, 16'hFFFF));
		plan.push_back(req(ACT_START, 16'd0, 1, 16'd0, KIND_NEW));
		plan.push_back(req(ACT_TICK, 16'd0, 1, 16'd0, KIND_RESENT));
		plan.push_back(req(ACT_ACK, 16'd0, 1, 16'd0, KIND_EXIT));
		// largest frame count, window above the maximum
		plan.push_back(wr(CFG_FRAME_COUNT, 16'hFFFF));
		plan.push_back(wr(CFG_WINDOW_SIZE, 16'd63));
		plan.push_back(wr(CFG_TIMEOUT, 16'd2));
		plan.push_back(req(ACT_START, 16'd0, 32, 16'd0, KIND_NEW));
		plan.push_back(req(ACT_TICK, 16'd0));
		plan.push_back(req(ACT_TICK, 16'd0, 32, 16'd0, KIND_RESENT));
		plan.push_back(req(ACT_ACK, 16'd0));
		plan.push_back(req(ACT_ACK, 16'd0));                    // stale ack
		plan.push_back(req(ACT_ACK, 16'hFFFE, 1, 16'd0, KIND_EXIT));
		plan.push_back(req(ACT_ACK, 16'hFFFE, 0));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				drain();
				cfg_write(plan[i].reg_sel, plan[i].value);
			end else begin
				push_request(plan[i].act, plan[i].ack, plan[i].n_exp, plan[i].first,
					plan[i].kind);
			end
		end

		// Random sessions, new register settings between them
		goal  = counted + RANDOM_ITEMS;
		phase = 0;
		while (counted < goal) begin
			drain();
			case ($urandom_range(0, 9))
				0:       frames = 16'd0;
				1:       frames = 16'hFFFF;
				2:       frames = 16'd1;
				default: frames = 16'($urandom_range(2, 40));
			endcase
			case ($urandom_range(0, 9))
				0:       window = 16'd0;
				1:       window = 16'd32;
				2:       window = 16'($urandom_range(33, 63));
				3:       window = 16'($urandom);
				default: window = 16'($urandom_range(1, 8));
			endcase
			case ($urandom_range(0, 9))
				0:       ticks = 16'd0;
				1:       ticks = 16'hFFFF;
				default: ticks = 16'($urandom_range(1, 4));
			endcase
			if (phase == 0) begin
				frames = 16'd5;
				window = 16'd32;
				ticks  = 16'hFFFF;
			end
			cfg_write(CFG_FRAME_COUNT, frames);
			cfg_write(CFG_WINDOW_SIZE, window);
			cfg_write(CFG_TIMEOUT, ticks);

			push_request(ACT_START, 16'($urandom));
			steps = $urandom_range(4, 18);
			for (int s = 0; s < steps && sess_on; s++) begin
				quiet = (counted >= goal - 12);
				pick  = $urandom_range(0, 19);
				if (pick < 10)
					push_request(ACT_ACK, base_num);
				else if (pick < 15)
					push_request(ACT_TICK, 16'($urandom));
				else if (pick < 17)
					push_request(ACT_ACK, 16'($urandom_range(0, 40)));
				else if (pick == 17)
					push_request(ACT_ACK, 16'($urandom));
				else if (pick == 18)
					push_request(ACT_UNKNOWN, 16'($urandom));
				else
					push_request(ACT_START, 16'($urandom));
			end
			// usually close the session; an open one carries into the next setting
			if (sess_on && $urandom_range(0, 3) != 0)
				push_request(ACT_ACK, (cfg_frames == 16'd0) ? 16'd0 : cfg_frames - 16'd1);
			if (!sess_on && $urandom_range(0, 2) == 0)
				push_request(2'($urandom_range(1, 3)), 16'($urandom));
			phase++;
		end

		drain();
		if (errors == 0 && frames_due.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
